@@ rtl/csi_pkg.sv @@
// Shared definitions for the circle / segment intersection test.
// Holds the default coordinate width and the stage advance controls
// handed from the top level to the wide square compare unit.
package csi_pkg;

  localparam int CSI_COORD_WIDTH = 32;

  // Load enables for the two register stages inside the compare unit.
  typedef struct packed {
    logic pp_en;
    logic acc_en;
  } csi_adv_t;

endpackage

@@ rtl/circle_segment_intersect_test.sv @@
// Top level of the circle / line segment intersection test pipeline.
// Depends on csi_pkg and on csi_sqcmp for the wide perpendicular compare.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------
//  input   | in_center_x/y, in_radius, in_start_x/y, | in_valid / in_ready
//          | in_end_x/y                              |
//  result  | out_hit                                 | out_valid / out_ready
//
// One item per cycle is accepted while in_ready is high (no stall holds it).
// The item passes seven registers, the first loaded at the accepting
// edge: differences, products, sums, classification, two stages of the wide
// square compare, then the output register. Each stage loads whenever it
// is empty or the stage after it advances, so bubbles close up under a stall
// and nothing is lost or repeated. Reset (rst_n, synchronous) clears only the
// valid bits; the block holds no state between items.
module circle_segment_intersect_test import csi_pkg::*; #(
  parameter int COORD_WIDTH = CSI_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic        [COORD_WIDTH-2:0] in_radius,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;      // coordinate differences
  localparam int PW = 2 * DW;     // products; also the compare unit operand width
  localparam int SW = PW + 1;     // sums of products
  localparam int NS = 6;          // pipeline stages ahead of the output register

  // Handshake and stage enables.
  logic [NS:1]   v_r;
  logic          out_valid_r;
  logic [NS+1:1] en;

  always_comb begin
    en[NS+1] = !out_valid_r || out_ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (en[NS+1]) begin
        out_valid_r <= v_r[NS];
      end
    end
  end

  // Stage 1: differences relative to the endpoints.
  logic signed [DW-1:0] dx_nxt, dy_nxt, px_nxt, py_nxt, qx_nxt, qy_nxt;
  logic signed [DW-1:0] dx_r, dy_r, px_r, py_r, qx_r, qy_r;
  logic        [W-2:0]  rad_r;

  assign dx_nxt = {in_end_x[W-1], in_end_x} - {in_start_x[W-1], in_start_x};
  assign dy_nxt = {in_end_y[W-1], in_end_y} - {in_start_y[W-1], in_start_y};
  assign px_nxt = {in_center_x[W-1], in_center_x} - {in_start_x[W-1], in_start_x};
  assign py_nxt = {in_center_y[W-1], in_center_y} - {in_start_y[W-1], in_start_y};
  assign qx_nxt = {in_center_x[W-1], in_center_x} - {in_end_x[W-1], in_end_x};
  assign qy_nxt = {in_center_y[W-1], in_center_y} - {in_end_y[W-1], in_end_y};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      qx_r  <= qx_nxt;
      qy_r  <= qy_nxt;
      rad_r <= in_radius;
    end
  end

  // Stage 2: all products, one multiplier each.
  logic signed [PW-1:0] m_dxdx_r, m_dydy_r, m_pxdx_r, m_pydy_r, m_pxpx_r, m_pypy_r;
  logic signed [PW-1:0] m_qxqx_r, m_qyqy_r, m_pxdy_r, m_pydx_r;
  logic        [PW-1:0] m_rr_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m_dxdx_r <= dx_r * dx_r;
      m_dydy_r <= dy_r * dy_r;
      m_pxdx_r <= px_r * dx_r;
      m_pydy_r <= py_r * dy_r;
      m_pxpx_r <= px_r * px_r;
      m_pypy_r <= py_r * py_r;
      m_qxqx_r <= qx_r * qx_r;
      m_qyqy_r <= qy_r * qy_r;
      m_pxdy_r <= px_r * dy_r;
      m_pydx_r <= py_r * dx_r;
      m_rr_r   <= rad_r * rad_r;
    end
  end

  // Stage 3: squared lengths, projection and cross product.
  logic signed [SW-1:0] seg2_r, proj_r, dist_s_r, dist_e_r, cross_r;
  logic        [PW-1:0] r2_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      seg2_r   <= m_dxdx_r + m_dydy_r;
      proj_r   <= m_pxdx_r + m_pydy_r;
      dist_s_r <= m_pxpx_r + m_pypy_r;
      dist_e_r <= m_qxqx_r + m_qyqy_r;
      cross_r  <= m_pxdy_r - m_pydx_r;
      r2_r     <= m_rr_r;
    end
  end

  // Stage 4: decide which region the projection falls in and settle the
  // endpoint cases. A zero-length segment counts as the start point.
  logic signed [SW-1:0] r2_ext;
  logic        [SW-1:0] cross_abs;
  logic                 near_start, past_end;
  logic                 fixed_nxt, fix_hit_nxt;
  logic                 fixed4_r, fix_hit4_r;
  logic        [PW-1:0] cmp_a_r, cmp_b_r, cmp_c_r;

  assign r2_ext     = $signed({1'b0, r2_r});
  assign cross_abs  = cross_r[SW-1] ? -cross_r : cross_r;
  assign near_start = (seg2_r == '0) || proj_r[SW-1] || (proj_r == '0);
  assign past_end   = (proj_r >= seg2_r);
  assign fixed_nxt  = near_start || past_end;
  assign fix_hit_nxt = near_start ? (dist_s_r <= r2_ext) : (dist_e_r <= r2_ext);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      fixed4_r   <= fixed_nxt;
      fix_hit4_r <= fix_hit_nxt;
      cmp_a_r    <= cross_abs[PW-1:0];
      cmp_b_r    <= r2_r;
      cmp_c_r    <= seg2_r[PW-1:0];
    end
  end

  // Stages 5 and 6: cross^2 <= r^2 * seg^2 in the compare unit, while the
  // endpoint decision rides alongside.
  csi_adv_t adv;
  logic     perp_le;
  logic     fixed5_r, fix_hit5_r, fixed6_r, fix_hit6_r;

  assign adv.pp_en  = en[5];
  assign adv.acc_en = en[6];

  csi_sqcmp #(
    .HALF_WIDTH(DW)
  ) u_sqcmp (
    .clk  (clk),
    .adv  (adv),
    .a_in (cmp_a_r),
    .b_in (cmp_b_r),
    .c_in (cmp_c_r),
    .le   (perp_le)
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      fixed5_r   <= fixed4_r;
      fix_hit5_r <= fix_hit4_r;
    end
    if (en[6]) begin
      fixed6_r   <= fixed5_r;
      fix_hit6_r <= fix_hit5_r;
    end
  end

  // Output register.
  logic out_hit_nxt;
  logic out_hit_r;

  assign out_hit_nxt = fixed6_r ? fix_hit6_r : perp_le;

  always_ff @(posedge clk) begin
    if (en[NS+1]) begin
      out_hit_r <= out_hit_nxt;
    end
  end

  assign out_hit = out_hit_r;

endmodule

@@ rtl/csi_sqcmp.sv @@
// Pipelined exact compare of a*a against b*c on unsigned 2*HALF_WIDTH-bit operands.
// Depends on csi_pkg for the stage advance struct.
module csi_sqcmp import csi_pkg::*; #(
  parameter int HALF_WIDTH = CSI_COORD_WIDTH + 1
) (
  input  logic                      clk,
  input  csi_adv_t                  adv,
  input  logic [2*HALF_WIDTH-1:0]   a_in,
  input  logic [2*HALF_WIDTH-1:0]   b_in,
  input  logic [2*HALF_WIDTH-1:0]   c_in,
  output logic                      le
);

  localparam int H  = HALF_WIDTH;
  localparam int PW = 2 * H;
  localparam int FW = 4 * H;

  logic [H-1:0]  ah, al, bh, bl, ch, cl;

  logic [PW-1:0] aa_hh_r, aa_hl_r, aa_ll_r;
  logic [PW-1:0] bc_hh_r, bc_hl_r, bc_lh_r, bc_ll_r;

  logic [PW:0]   bc_mid_nxt;
  logic [FW-1:0] sq_nxt, prod_nxt;
  logic [FW-1:0] sq_r, prod_r;

  assign ah = a_in[PW-1:H];
  assign al = a_in[H-1:0];
  assign bh = b_in[PW-1:H];
  assign bl = b_in[H-1:0];
  assign ch = c_in[PW-1:H];
  assign cl = c_in[H-1:0];

  // First stage: half-width partial products only.
  always_ff @(posedge clk) begin
    if (adv.pp_en) begin
      aa_hh_r <= ah * ah;
      aa_hl_r <= ah * al;
      aa_ll_r <= al * al;
      bc_hh_r <= bh * ch;
      bc_hl_r <= bh * cl;
      bc_lh_r <= bl * ch;
      bc_ll_r <= bl * cl;
    end
  end

  // The square has one cross term, counted twice, so it is shifted one place further.
  assign sq_nxt = {aa_hh_r, aa_ll_r} + (FW'(aa_hl_r) << (H + 1));
  assign bc_mid_nxt = (PW + 1)'(bc_hl_r) + (PW + 1)'(bc_lh_r);
  assign prod_nxt = {bc_hh_r, bc_ll_r} + (FW'(bc_mid_nxt) << H);

  always_ff @(posedge clk) begin
    if (adv.acc_en) begin
      sq_r   <= sq_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign le = (sq_r <= prod_r);

endmodule

@@ dv/tb_circle_segment_intersect_test.sv @@
// Self-checking testbench for circle_segment_intersect_test.
// Predicts every hit flag with exact 256-bit integer arithmetic and checks the
// results in order; depends on csi_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_circle_segment_intersect_test;
  import csi_pkg::*;

  localparam int CW = CSI_COORD_WIDTH;
  localparam int DRAIN_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 112;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-2:0] R_MAX = '1;

  typedef logic signed [255:0] exact_t;

  typedef struct {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic        [CW-2:0] radius;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } query_t;

  typedef enum {Q_WIDE, Q_LOCAL, Q_POINT, Q_EDGE} query_kind_t;

  class hit_scoreboard;
    bit     hit_q[$];
    query_t query_q[$];
    int     errors;
    int     checked;
    int     hits;

    // Closest point of the segment to the center, decided without division:
    // the perpendicular distance is compared after scaling by the squared length.
    function bit predict_hit(query_t q);
      exact_t cx, cy, rr, sx, sy, ex, ey;
      exact_t dx, dy, px, py, r2, seg2, along, perp_x;
      cx = exact_t'(q.center_x);
      cy = exact_t'(q.center_y);
      rr = exact_t'(q.radius);
      sx = exact_t'(q.start_x);
      sy = exact_t'(q.start_y);
      ex = exact_t'(q.end_x);
      ey = exact_t'(q.end_y);
      dx = ex - sx;
      dy = ey - sy;
      px = cx - sx;
      py = cy - sy;
      r2 = rr * rr;
      seg2 = dx * dx + dy * dy;
      along = px * dx + py * dy;
      if (seg2 == 0 || along <= 0)
        return (px * px + py * py) <= r2;
      if (along >= seg2)
        return ((cx - ex) * (cx - ex) + (cy - ey) * (cy - ey)) <= r2;
      perp_x = px * dy - py * dx;
      return (perp_x * perp_x) <= (r2 * seg2);
    endfunction

    function void note_query(query_t q);
      hit_q.push_back(predict_hit(q));
      query_q.push_back(q);
    endfunction

    function int pending();
      return hit_q.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    task check_hit(logic got);
      bit     want;
      query_t q;
      if (hit_q.size() == 0) begin
        report_mismatch($sformatf("result hit=%b with no item outstanding", got));
        return;
      end
      want = hit_q.pop_front();
      q = query_q.pop_front();
      checked++;
      if (got === 1'b1)
        hits++;
      if (got !== want)
        report_mismatch($sformatf(
          "center (%0d,%0d) r %0d seg (%0d,%0d)-(%0d,%0d): hit %b, expected %b",
          q.center_x, q.center_y, q.radius, q.start_x, q.start_y, q.end_x, q.end_y,
          got, want));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_center_x = '0;
  logic signed [CW-1:0] in_center_y = '0;
  logic        [CW-2:0] in_radius = '0;
  logic signed [CW-1:0] in_start_x = '0;
  logic signed [CW-1:0] in_start_y = '0;
  logic signed [CW-1:0] in_end_x = '0;
  logic signed [CW-1:0] in_end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_cycles = 0;
  hit_scoreboard sb;

  circle_segment_intersect_test #(.COORD_WIDTH(CW)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_radius  (in_radius),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Handshakes are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_query('{in_center_x, in_center_y, in_radius, in_start_x, in_start_y,
                      in_end_x, in_end_y});
    if (rst_n && out_valid && out_ready)
      sb.check_hit(out_hit);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic query_t mk(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                logic [CW-2:0] r, logic signed [CW-1:0] sx,
                                logic signed [CW-1:0] sy, logic signed [CW-1:0] ex,
                                logic signed [CW-1:0] ey);
    query_t q;
    q = '{cx, cy, r, sx, sy, ex, ey};
    return q;
  endfunction

  function automatic int offset(int k);
    int span;
    span = 1 << k;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic query_t random_query();
    query_t      q;
    query_kind_t kind;
    int          roll, k, len, along, perp, rad;
    logic signed [CW-1:0] tx, ty;
    roll = $urandom_range(99);
    kind = roll < 25 ? Q_WIDE : roll < 70 ? Q_LOCAL : roll < 80 ? Q_POINT : Q_EDGE;
    q = '{$urandom, $urandom, (CW-1)'($urandom), $urandom, $urandom, $urandom,
          $urandom};
    case (kind)
      Q_WIDE: ;
      Q_LOCAL, Q_POINT: begin
        k = $urandom_range(1, 24);
        q.start_x = q.center_x + offset(k);
        q.start_y = q.center_y + offset(k);
        q.end_x = (kind == Q_POINT) ? q.start_x : q.start_x + offset(k);
        q.end_y = (kind == Q_POINT) ? q.start_y : q.start_y + offset(k);
        q.radius = (CW-1)'($urandom_range(0, 2 << k));
      end
      Q_EDGE: begin
        // Axis-aligned segment with the center at or one unit off the circle's edge.
        k = $urandom_range(1, 20);
        len = $urandom_range(1, 1 << k);
        along = int'($urandom_range(0, 2 * len)) - len / 2;
        perp = offset(k);
        if ($urandom_range(1)) begin
          q.start_x = q.center_x - perp;
          q.start_y = q.center_y - along;
          q.end_x = q.start_x;
          q.end_y = q.start_y + len;
        end else begin
          q.start_x = q.center_x - along;
          q.start_y = q.center_y - perp;
          q.end_x = q.start_x + len;
          q.end_y = q.start_y;
        end
        if ($urandom_range(1)) begin
          tx = q.start_x;
          ty = q.start_y;
          q.start_x = q.end_x;
          q.start_y = q.end_y;
          q.end_x = tx;
          q.end_y = ty;
        end
        rad = (perp < 0 ? -perp : perp) + int'($urandom_range(0, 2)) - 1;
        q.radius = (rad < 0) ? '0 : (CW-1)'(rad);
      end
    endcase
    return q;
  endfunction

  task automatic send_query(input query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_center_x <= q.center_x;
    in_center_y <= q.center_y;
    in_radius <= q.radius;
    in_start_x <= q.start_x;
    in_start_y <= q.start_y;
    in_end_x <= q.end_x;
    in_end_y <= q.end_y;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  task automatic run_directed();
    // Zero-length segment, on the edge and just outside.
    send_query(mk(5, 8, 3, 5, 5, 5, 5));
    send_query(mk(5, 8, 2, 5, 5, 5, 5));
    // Projection inside the segment, perpendicular distance exactly r, then r-1.
    send_query(mk(5, 3, 3, 0, 0, 10, 0));
    send_query(mk(5, 3, 2, 0, 0, 10, 0));
    send_query(mk(5, -3, 3, 10, 0, 0, 0));
    // Projection before the start point.
    send_query(mk(-3, 4, 5, 0, 0, 10, 0));
    send_query(mk(-3, 4, 4, 0, 0, 10, 0));
    // Projection exactly at the start and exactly at the end.
    send_query(mk(0, 7, 7, 0, 0, 10, 0));
    send_query(mk(10, 7, 7, 0, 0, 10, 0));
    send_query(mk(10, 7, 6, 0, 0, 10, 0));
    // Projection beyond the end point.
    send_query(mk(14, 3, 5, 0, 0, 10, 0));
    send_query(mk(14, 3, 4, 0, 0, 10, 0));
    // Extreme coordinates and radii.
    send_query(mk(C_MIN, C_MIN, 0, C_MAX, C_MAX, C_MIN, C_MIN));
    send_query(mk(C_MAX, C_MIN, R_MAX, C_MIN, C_MAX, C_MAX, C_MAX));
    send_query(mk(0, 0, R_MAX, C_MIN, C_MIN, C_MAX, C_MAX));
    send_query(mk(C_MAX, C_MAX, 0, C_MIN, C_MAX, C_MAX, C_MIN));
    send_query(mk(C_MIN, C_MAX, R_MAX, C_MIN, C_MAX, C_MIN, C_MAX));
    send_query(mk(C_MAX, 0, R_MAX, C_MIN, 0, C_MIN, 0));
    send_query(mk(0, 0, 0, 0, 0, 0, 0));
    send_query(mk(-1, -1, R_MAX, -1, -1, -1, -1));
  endtask

  initial begin
    int phase;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      repeat (ITEMS_PER_PHASE)
        send_query(random_query());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    $display("Ran %0d circle/segment queries (%0d hits, %0d misses): directed edge cases,",
             sb.checked, sb.hits, sb.checked - sb.hits);
    $display("then random queries under free-running, sender-idle, receiver-stall and mixed pacing.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
